// ===== rtl/fr_pkg.sv =====
`timescale 1ns / 1ps
package fr_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNumZero  = 2'd1,
    StatusDenZero  = 2'd2,
    StatusReserved = 2'd3
  } status_e;
endpackage

// ===== rtl/fr_if.sv =====
`timescale 1ns / 1ps
interface fr_in_if #(
  parameter int unsigned DW = fr_pkg::DataWidth
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] numer_in;
  logic [DW-1:0] denom_in;
  modport source (output valid, numer_in, denom_in, input ready);
  modport sink (input valid, numer_in, denom_in, output ready);
endinterface

interface fr_out_if #(
  parameter int unsigned DW = fr_pkg::DataWidth
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] numer_out;
  logic [DW-1:0] denom_out;
  logic [1:0]    status;
  modport source (output valid, numer_out, denom_out, status, input ready);
  modport sink (input valid, numer_out, denom_out, status, output ready);
endinterface

// ===== rtl/fr_front.sv =====
`timescale 1ns / 1ps
// Takes signed values, splits them into magnitudes and signs and classifies each item into a one-entry queue slot.
module fr_front #(
  parameter int unsigned DW = fr_pkg::DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fr_in_if.sink         in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output logic [DW-1:0] q_nmag_o,
  output logic [DW-1:0] q_dmag_o,
  output logic          q_nneg_o,
  output logic          q_dneg_o,
  output fr_pkg::status_e q_status_o
);
  import fr_pkg::*;

  logic          valid_q;
  logic [DW-1:0] nmag_q, dmag_q;
  logic          nneg_q, dneg_q;
  status_e       status_q, status_d;
  logic [DW-1:0] nmag_d, dmag_d;

  assign in_i.ready = !valid_q || q_ready_i;
  assign nmag_d = in_i.numer_in[DW-1] ? (~in_i.numer_in + 1'b1) : in_i.numer_in;
  assign dmag_d = in_i.denom_in[DW-1] ? (~in_i.denom_in + 1'b1) : in_i.denom_in;

  always_comb begin
    if (dmag_d == '0) begin
      status_d = StatusDenZero;
    end else if (nmag_d == '0) begin
      status_d = StatusNumZero;
    end else begin
      status_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      nmag_q   <= nmag_d;
      dmag_q   <= dmag_d;
      nneg_q   <= in_i.numer_in[DW-1];
      dneg_q   <= in_i.denom_in[DW-1];
      status_q <= status_d;
    end
  end

  assign q_valid_o  = valid_q;
  assign q_nmag_o   = nmag_q;
  assign q_dmag_o   = dmag_q;
  assign q_nneg_o   = nneg_q;
  assign q_dneg_o   = dneg_q;
  assign q_status_o = status_q;
endmodule

// ===== rtl/fr_back.sv =====
`timescale 1ns / 1ps
// Euclid by restoring division, then two more divisions by the gcd on the same unit.
module fr_back #(
  parameter int unsigned DW = fr_pkg::DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  logic [DW-1:0] q_nmag_i,
  input  logic [DW-1:0] q_dmag_i,
  input  logic          q_nneg_i,
  input  logic          q_dneg_i,
  input  fr_pkg::status_e q_status_i,
  fr_out_if.source      out_o
);
  import fr_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StGcd  = 5'b00010,
    StDivN = 5'b00100,
    StDivD = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [DW-1:0] b_q;               // Euclid divisor
  logic [DW-1:0] nmag_q, dmag_q, g_q;
  logic          nneg_q, dneg_q;
  logic [DW-1:0] rem_q, dvd_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] nres_q, dres_q;
  status_e       st_q;

  // One restoring step: shift in next dividend bit, subtract divisor if possible.
  logic [DW:0]   trial;
  logic [DW-1:0] divisor;
  logic [DW-1:0] rem_n;
  logic          take;

  assign divisor = (state_q == StGcd) ? b_q : g_q;
  assign trial   = {rem_q, dvd_q[DW-1]};
  assign take    = trial >= {1'b0, divisor};
  assign rem_n   = take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];

  assign q_ready_o = (state_q == StIdle);
  assign out_o.valid     = (state_q == StOut);
  assign out_o.numer_out = nres_q;
  assign out_o.denom_out = dres_q;
  assign out_o.status    = st_q;

  logic last;
  assign last = (cnt_q == CW'(DW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i) state_d = (q_status_i == StatusOk) ? StGcd : StOut;
      StGcd:  if (last && rem_n == '0) state_d = StDivN;
      StDivN: if (last) state_d = StDivD;
      StDivD: if (last) state_d = StOut;
      StOut:  if (out_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle || last) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        nmag_q <= q_nmag_i;
        dmag_q <= q_dmag_i;
        nneg_q <= q_nneg_i;
        dneg_q <= q_dneg_i;
        st_q   <= q_status_i;
        b_q    <= q_dmag_i;
        dvd_q  <= q_nmag_i;
        rem_q  <= '0;
        nres_q <= '0;
        dres_q <= '0;
      end
      StGcd: begin
        rem_q <= rem_n;
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
        if (last) begin
          rem_q <= '0;
          if (rem_n == '0) begin
            g_q   <= b_q;
            dvd_q <= nmag_q;
          end else begin
            b_q   <= rem_n;
            dvd_q <= b_q;
          end
        end
      end
      StDivN, StDivD: begin
        rem_q <= rem_n;
        dvd_q <= {dvd_q[DW-2:0], take};
        if (last) begin
          rem_q <= '0;
          dvd_q <= dmag_q;
          if (state_q == StDivN) begin
            nres_q <= nneg_q ? (~{dvd_q[DW-2:0], take} + 1'b1) : {dvd_q[DW-2:0], take};
          end else begin
            dres_q <= dneg_q ? (~{dvd_q[DW-2:0], take} + 1'b1) : {dvd_q[DW-2:0], take};
          end
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("back state not one-hot");
  a_nooverlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !q_ready_o) else $error("accepting while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.numer_out)))
    else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.status != StatusReserved) else $error("bad status");
`endif
endmodule

// ===== rtl/fraction_reducer_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Fields
// in_i    | sink      | numer_in, denom_in
// out_o   | source    | numer_out, denom_out, status
// An item passes the one-entry queue, then runs the Euclid remainder steps and then the
// two quotient divisions, all on the shared restoring divider.
// Zero numerator or denominator items skip the divider and go straight to the output.
// Reset clears control state only; one item waits in the queue while another works.
module fraction_reducer_core #(
  parameter int unsigned DATA_WIDTH = fr_pkg::DataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  fr_in_if.sink     in_i,
  fr_out_if.source  out_o
);
  import fr_pkg::*;

  logic                  q_valid, q_ready, q_nneg, q_dneg;
  logic [DATA_WIDTH-1:0] q_nmag, q_dmag;
  status_e               q_status;

  fr_front #(.DW(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_nmag_o(q_nmag), .q_dmag_o(q_dmag),
    .q_nneg_o(q_nneg), .q_dneg_o(q_dneg), .q_status_o(q_status)
  );

  fr_back #(.DW(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_nmag_i(q_nmag), .q_dmag_i(q_dmag),
    .q_nneg_i(q_nneg), .q_dneg_i(q_dneg), .q_status_i(q_status), .out_o
  );
endmodule

// ===== tb/sv/fr_checker.sv =====
`timescale 1ns / 1ps
module fr_checker #(
  parameter int unsigned DW = fr_pkg::DataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fr_in_if.sink       in_i,
  fr_out_if.sink      out_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import fr_pkg::*;

  typedef struct packed {
    logic [DW-1:0] numer;
    logic [DW-1:0] denom;
    status_e       status;
  } reduced_t;

  reduced_t reduced_q[$];
  int unsigned fails;

  function automatic logic [DW-1:0] abs_val(logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DW-1:0] euclid_gcd(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic reduced_t reduce_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
    reduced_t res;
    logic [DW-1:0] nm, dm, g, nq, dq;
    nm = abs_val(n);
    dm = abs_val(d);
    res = '{numer: '0, denom: '0, status: StatusOk};
    if (dm == '0) begin
      res.status = StatusDenZero;
    end else if (nm == '0) begin
      res.status = StatusNumZero;
    end else begin
      g = euclid_gcd(nm, dm);
      if (g == '0) g = 1;
      nq = nm / g;
      dq = dm / g;
      res.numer = n[DW-1] ? (~nq + 1'b1) : nq;
      res.denom = d[DW-1] ? (~dq + 1'b1) : dq;
    end
    return res;
  endfunction

  assign fail_count_o = fails;
  assign pending_o    = reduced_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reduced_t want;
    if (!rst_ni) begin
      fails = 0;
      reduced_q.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        reduced_q.push_back(reduce_fraction(in_i.numer_in, in_i.denom_in));
      end
      if (out_o.valid && out_o.ready) begin
        if (reduced_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fails++;
        end else begin
          want = reduced_q.pop_front();
          if (out_o.numer_out !== want.numer) begin
            $error("numer_out: expected %0d, got %0d", $signed(want.numer),
                   $signed(out_o.numer_out));
            fails++;
          end
          if (out_o.denom_out !== want.denom) begin
            $error("denom_out: expected %0d, got %0d", $signed(want.denom),
                   $signed(out_o.denom_out));
            fails++;
          end
          if (out_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_o.status);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import fr_pkg::*;

  localparam int unsigned DW = DataWidth;
  localparam int unsigned RandomItems = 1030;
  localparam int unsigned StallLimit = 40000;
  localparam logic [DW-1:0] MaxPos = {1'b0, {(DW-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;
  int unsigned fail_count, pending, quiet_cycles;

  fr_in_if  #(.DW(DW)) in_ch ();
  fr_out_if #(.DW(DW)) out_ch ();

  fraction_reducer_core #(.DATA_WIDTH(DW)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  fr_checker #(.DW(DW)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.numer_in = '0;
    in_ch.denom_in = '0;
    out_ch.ready   = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off after a number of transfers.
  always @(posedge clk_i) begin
    int unsigned taken, hold;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) taken++;
      if (taken == 40 && hold == 0) hold = 3000;
      if (hold > 1) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (hold == 1) begin
          hold = 0;
          taken++;
        end
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_fraction(input logic [DW-1:0] n, input logic [DW-1:0] d);
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.numer_in <= n;
    in_ch.denom_in <= d;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] neg_of(logic [DW-1:0] v);
    return ~v + 1'b1;
  endfunction

  function automatic logic [DW-1:0] any_value();
    logic [DW-1:0] v;
    v = $urandom;
    if (v == {1'b1, {(DW-1){1'b0}}}) v = MaxPos;
    return v;
  endfunction

  function automatic logic [DW-1:0] signed_small(int unsigned top);
    logic [DW-1:0] v;
    v = $urandom_range(1, top);
    return $urandom_range(1) ? neg_of(v) : v;
  endfunction

  initial begin
    logic [DW-1:0] n, d, g;
    int unsigned kind;
    in_ch.valid <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fraction('0, '0);
    send_fraction(5, '0);
    send_fraction(neg_of(9), '0);
    send_fraction('0, 7);
    send_fraction('0, neg_of(7));
    send_fraction(1, 1);
    send_fraction(neg_of(1), neg_of(1));
    send_fraction(3, neg_of(6));
    send_fraction(neg_of(12), neg_of(18));
    send_fraction(6, 4);
    send_fraction(MaxPos, MaxPos);
    send_fraction(neg_of(MaxPos), MaxPos);
    send_fraction(MaxPos, 1);
    send_fraction(1, neg_of(MaxPos));
    send_fraction(MaxPos, MaxPos - 1);
    send_fraction(32'h4000_0000, 32'h2000_0000);
    send_fraction(1836311903, 1134903170);
    send_fraction(neg_of(1134903170), 701408733);
    send_fraction(2147483629, 2147483587);
    send_fraction(neg_of(MaxPos), neg_of(MaxPos));
    send_fraction(32'h5555_5555, 32'h2AAA_AAAA);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      calm <= (i >= 400 && i < 550);
      kind = $urandom_range(99);
      if (kind < 5) begin
        n = $urandom_range(1) ? any_value() : '0;
        d = '0;
      end else if (kind < 10) begin
        n = '0;
        d = any_value();
        if (d == '0) d = 3;
      end else if (kind < 45) begin
        n = signed_small(1000);
        d = signed_small(1000);
      end else if (kind < 75) begin
        g = $urandom_range(1, 65535);
        n = g * $urandom_range(1, 32767);
        d = g * $urandom_range(1, 32767);
        if ($urandom_range(1)) n = neg_of(n);
        if ($urandom_range(1)) d = neg_of(d);
      end else begin
        n = any_value();
        d = any_value();
        if (d == '0) d = 1;
      end
      send_fraction(n, d);
    end
    in_ch.valid <= 1'b0;
    calm <= 1'b0;

    // Let the checker record the last transfer before looking at what is outstanding.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
